// File: rtl/psp_pkg.sv
// Shared constants and types for the point-to-segment proximity pipeline.
package psp_pkg;

   // Radius scaling, radius field and derived widths
   localparam int RADIUS_W     = 12;
   localparam int RADIUS_SHIFT = 4;
   localparam int ND_W         = RADIUS_W + RADIUS_SHIFT;
   localparam int ND2_W        = 2 * ND_W;

   // Result word width and pipeline depth ahead of the output register
   localparam int RSP_W        = 8;
   localparam int NUM_STAGES   = 6;

   // Outcome of the branch tests, refined once the dot products are known
   typedef enum logic [2:0] {
      SEL_ZERO,
      SEL_ONE,
      SEL_D1,
      SEL_D2,
      SEL_GEN
   } sel_type;

endpackage

// File: rtl/psp_front.sv
// Front stages: coordinate differences, products with branch tests, and their sums.
module psp_front import psp_pkg::*; #(
   parameter int  COORD_BITS = 18,
   localparam int DIFF_W     = COORD_BITS + 1,
   localparam int SQ_W       = 2 * COORD_BITS + 1,
   localparam int SUM_W      = 2 * COORD_BITS + 2
) (
   input  logic                         clock,
   input  logic [2:0]                   stage_en,
   input  logic signed [COORD_BITS-1:0] point_x,
   input  logic signed [COORD_BITS-1:0] point_y,
   input  logic signed [COORD_BITS-1:0] start_x,
   input  logic signed [COORD_BITS-1:0] start_y,
   input  logic signed [COORD_BITS-1:0] end_x,
   input  logic signed [COORD_BITS-1:0] end_y,
   input  logic [RADIUS_W-1:0]          radius,
   output sel_type                      sel,
   output logic [SQ_W-1:0]              d1,
   output logic [SQ_W-1:0]              d2,
   output logic [ND2_W-1:0]             nd2,
   output logic signed [SUM_W-1:0]      dot1,
   output logic signed [SUM_W-1:0]      dot2,
   output logic signed [SUM_W-1:0]      cross_prod,
   output logic [SQ_W-1:0]              len2
);

   localparam int PROD_W = SQ_W;
   localparam int CMP_W  = (DIFF_W + 1 > ND_W + 1) ? DIFF_W + 1 : ND_W + 1;

   // Stage 1: differences and scaled radius
   logic signed [DIFF_W-1:0] dx_in, dy_in, a1x_in, a1y_in, a2x_in, a2y_in;
   logic signed [DIFF_W-1:0] dx_ff, dy_ff, a1x_ff, a1y_ff, a2x_ff, a2y_ff;
   logic [ND_W-1:0]          nd_in, nd_ff;

   // Stage 2: products and branch outcome
   logic signed [PROD_W-1:0] sq_a1x_in, sq_a1y_in, sq_a2x_in, sq_a2y_in, sq_dx_in, sq_dy_in;
   logic signed [PROD_W-1:0] sq_a1x_ff, sq_a1y_ff, sq_a2x_ff, sq_a2y_ff, sq_dx_ff, sq_dy_ff;
   logic signed [PROD_W-1:0] p_a2x_dx_in, p_dy_a2y_in, p_a1x_dx_in, p_dy_a1y_in;
   logic signed [PROD_W-1:0] p_a2x_dx_ff, p_dy_a2y_ff, p_a1x_dx_ff, p_dy_a1y_ff;
   logic signed [PROD_W-1:0] p_a1x_dy_in, p_dx_a1y_in, p_a1x_dy_ff, p_dx_a1y_ff;
   logic [ND2_W-1:0]         nd2_s2_in, nd2_s2_ff;
   sel_type                  sel_s2_in, sel_s2_ff;

   // Stage 3: sums
   logic [SQ_W-1:0]          d1_in, d2_in, len2_in, d1_ff, d2_ff, len2_ff;
   logic signed [SUM_W-1:0]  dot1_in, dot2_in, cross_in, dot1_ff, dot2_ff, cross_ff;
   logic [ND2_W-1:0]         nd2_ff;
   sel_type                  sel_ff;

   // Branch test helpers
   logic signed [CMP_W-1:0]  ndc, nndc, a1x_c, a1y_c, a2x_c, a2y_c;
   logic                     dx_pos, dx_zero, dy_pos, dy_zero, xrej, yrej;

   // Form the differences against both endpoints
   always_comb begin
      dx_in  = DIFF_W'(end_x)   - DIFF_W'(start_x);
      dy_in  = DIFF_W'(end_y)   - DIFF_W'(start_y);
      a1x_in = DIFF_W'(point_x) - DIFF_W'(start_x);
      a1y_in = DIFF_W'(point_y) - DIFF_W'(start_y);
      a2x_in = DIFF_W'(point_x) - DIFF_W'(end_x);
      a2y_in = DIFF_W'(point_y) - DIFF_W'(end_y);
      nd_in  = {radius, {RADIUS_SHIFT{1'b0}}};
   end

   // Multiply every pair the later tests need
   always_comb begin
      sq_a1x_in   = PROD_W'(a1x_ff) * PROD_W'(a1x_ff);
      sq_a1y_in   = PROD_W'(a1y_ff) * PROD_W'(a1y_ff);
      sq_a2x_in   = PROD_W'(a2x_ff) * PROD_W'(a2x_ff);
      sq_a2y_in   = PROD_W'(a2y_ff) * PROD_W'(a2y_ff);
      sq_dx_in    = PROD_W'(dx_ff)  * PROD_W'(dx_ff);
      sq_dy_in    = PROD_W'(dy_ff)  * PROD_W'(dy_ff);
      p_a2x_dx_in = PROD_W'(a2x_ff) * PROD_W'(dx_ff);
      p_dy_a2y_in = PROD_W'(dy_ff)  * PROD_W'(a2y_ff);
      p_a1x_dx_in = PROD_W'(a1x_ff) * PROD_W'(dx_ff);
      p_dy_a1y_in = PROD_W'(dy_ff)  * PROD_W'(a1y_ff);
      p_a1x_dy_in = PROD_W'(a1x_ff) * PROD_W'(dy_ff);
      p_dx_a1y_in = PROD_W'(dx_ff)  * PROD_W'(a1y_ff);
      nd2_s2_in   = ND2_W'(nd_ff) * ND2_W'(nd_ff);
   end

   // Resolve the bounding box and the vertical and horizontal wall branches
   always_comb begin
      ndc     = signed'(CMP_W'(nd_ff));
      nndc    = -ndc;
      a1x_c   = CMP_W'(a1x_ff);
      a1y_c   = CMP_W'(a1y_ff);
      a2x_c   = CMP_W'(a2x_ff);
      a2y_c   = CMP_W'(a2y_ff);
      dx_zero = (dx_ff == '0);
      dy_zero = (dy_ff == '0);
      dx_pos  = !dx_ff[DIFF_W-1] && !dx_zero;
      dy_pos  = !dy_ff[DIFF_W-1] && !dy_zero;
      xrej    = dx_pos ? (a1x_c <= nndc || a2x_c >= ndc) : (a2x_c <= nndc || a1x_c >= ndc);
      yrej    = dy_pos ? (a1y_c <= nndc || a2y_c >= ndc) : (a2y_c <= nndc || a1y_c >= ndc);

      if (xrej) begin
         sel_s2_in = SEL_ZERO;
      end else if (dx_zero) begin
         if (yrej) begin
            sel_s2_in = SEL_ZERO;
         end else if (dy_pos) begin
            if (a1y_c < 0)      sel_s2_in = SEL_D1;
            else if (a2y_c > 0) sel_s2_in = SEL_D2;
            else                sel_s2_in = SEL_ONE;
         end else begin
            if (a2y_c < 0)      sel_s2_in = SEL_D2;
            else if (a1y_c > 0) sel_s2_in = SEL_D1;
            else                sel_s2_in = SEL_ONE;
         end
      end else if (yrej) begin
         sel_s2_in = SEL_ZERO;
      end else if (dy_zero && dx_pos && a1x_c < 0) begin
         sel_s2_in = SEL_D1;
      end else if (dy_zero && dx_pos && a2x_c > 0) begin
         sel_s2_in = SEL_D2;
      end else if (dy_zero && !dx_pos && a2x_c < 0) begin
         sel_s2_in = SEL_D2;
      end else if (dy_zero && !dx_pos && a1x_c > 0) begin
         sel_s2_in = SEL_D1;
      end else begin
         sel_s2_in = SEL_GEN;
      end
   end

   // Add the products into distances, dot products and the cross product
   always_comb begin
      d1_in    = $unsigned(sq_a1x_ff) + $unsigned(sq_a1y_ff);
      d2_in    = $unsigned(sq_a2x_ff) + $unsigned(sq_a2y_ff);
      len2_in  = $unsigned(sq_dx_ff)  + $unsigned(sq_dy_ff);
      dot2_in  = SUM_W'(p_a2x_dx_ff) + SUM_W'(p_dy_a2y_ff);
      dot1_in  = SUM_W'(p_a1x_dx_ff) + SUM_W'(p_dy_a1y_ff);
      cross_in = SUM_W'(p_a1x_dy_ff) - SUM_W'(p_dx_a1y_ff);
   end

   // Advance each stage when the stage after it can take the word
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         a1x_ff <= a1x_in;
         a1y_ff <= a1y_in;
         a2x_ff <= a2x_in;
         a2y_ff <= a2y_in;
         nd_ff  <= nd_in;
      end
      if (stage_en[1]) begin
         sq_a1x_ff   <= sq_a1x_in;
         sq_a1y_ff   <= sq_a1y_in;
         sq_a2x_ff   <= sq_a2x_in;
         sq_a2y_ff   <= sq_a2y_in;
         sq_dx_ff    <= sq_dx_in;
         sq_dy_ff    <= sq_dy_in;
         p_a2x_dx_ff <= p_a2x_dx_in;
         p_dy_a2y_ff <= p_dy_a2y_in;
         p_a1x_dx_ff <= p_a1x_dx_in;
         p_dy_a1y_ff <= p_dy_a1y_in;
         p_a1x_dy_ff <= p_a1x_dy_in;
         p_dx_a1y_ff <= p_dx_a1y_in;
         nd2_s2_ff   <= nd2_s2_in;
         sel_s2_ff   <= sel_s2_in;
      end
      if (stage_en[2]) begin
         d1_ff    <= d1_in;
         d2_ff    <= d2_in;
         len2_ff  <= len2_in;
         dot1_ff  <= dot1_in;
         dot2_ff  <= dot2_in;
         cross_ff <= cross_in;
         nd2_ff   <= nd2_s2_ff;
         sel_ff   <= sel_s2_ff;
      end
   end

   assign sel        = sel_ff;
   assign d1         = d1_ff;
   assign d2         = d2_ff;
   assign nd2        = nd2_ff;
   assign dot1       = dot1_ff;
   assign dot2       = dot2_ff;
   assign cross_prod = cross_ff;
   assign len2       = len2_ff;

endmodule

// File: rtl/psp_select.sv
// Selection stage: endpoint distance compares, projection tests and cross magnitude.
module psp_select import psp_pkg::*; #(
   parameter int  COORD_BITS = 18,
   localparam int SQ_W       = 2 * COORD_BITS + 1,
   localparam int SUM_W      = 2 * COORD_BITS + 2
) (
   input  logic                    clock,
   input  logic                    stage_en,
   input  sel_type                 sel,
   input  logic [SQ_W-1:0]         d1,
   input  logic [SQ_W-1:0]         d2,
   input  logic [ND2_W-1:0]        nd2,
   input  logic signed [SUM_W-1:0] dot1,
   input  logic signed [SUM_W-1:0] dot2,
   input  logic signed [SUM_W-1:0] cross_prod,
   input  logic [SQ_W-1:0]         len2,
   output logic                    known,
   output logic                    known_val,
   output logic [SQ_W-1:0]         mag,
   output logic [SQ_W-1:0]         len2_out,
   output logic [ND2_W-1:0]        nd2_out
);

   localparam int LT_W = (SQ_W > ND2_W) ? SQ_W : ND2_W;

   logic                   d1_lt, d2_lt;
   logic                   known_in, known_ff, val_in, val_ff;
   logic signed [SUM_W-1:0] neg_cross;
   logic [SQ_W-1:0]        mag_in, mag_ff, len2_ff;
   logic [ND2_W-1:0]       nd2_ff;

   // Compare endpoint distances and take the cross magnitude
   always_comb begin
      d1_lt     = LT_W'(d1) < LT_W'(nd2);
      d2_lt     = LT_W'(d2) < LT_W'(nd2);
      neg_cross = -cross_prod;
      mag_in    = cross_prod[SUM_W-1] ? SQ_W'(neg_cross) : SQ_W'(cross_prod);
   end

   // Settle the answer unless it needs the perpendicular distance
   always_comb begin
      known_in = 1'b1;
      val_in   = 1'b0;
      case (sel)
         SEL_ZERO: val_in = 1'b0;
         SEL_ONE:  val_in = 1'b1;
         SEL_D1:   val_in = d1_lt;
         SEL_D2:   val_in = d2_lt;
         SEL_GEN: begin
            if (!dot2[SUM_W-1]) begin
               val_in = d2_lt;
            end else if (dot1[SUM_W-1] || dot1 == '0) begin
               val_in = d1_lt;
            end else begin
               known_in = 1'b0;
            end
         end
         default: val_in = 1'b0;
      endcase
   end

   // Hold while the next stage is stalled
   always_ff @(posedge clock) begin
      if (stage_en) begin
         known_ff <= known_in;
         val_ff   <= val_in;
         mag_ff   <= mag_in;
         len2_ff  <= len2;
         nd2_ff   <= nd2;
      end
   end

   assign known     = known_ff;
   assign known_val = val_ff;
   assign mag       = mag_ff;
   assign len2_out  = len2_ff;
   assign nd2_out   = nd2_ff;

endmodule

// File: rtl/psp_wide_cmp.sv
// Wide product stages: cross squared and length squared times radius squared, by halves.
module psp_wide_cmp import psp_pkg::*; #(
   parameter int  COORD_BITS = 18,
   localparam int SQ_W       = 2 * COORD_BITS + 1,
   localparam int LHS_W      = 2 * SQ_W,
   localparam int RHS_W      = SQ_W + ND2_W,
   localparam int WIDE_W     = (LHS_W > RHS_W) ? LHS_W : RHS_W
) (
   input  logic              clock,
   input  logic [1:0]        stage_en,
   input  logic              known,
   input  logic              known_val,
   input  logic [SQ_W-1:0]   mag,
   input  logic [SQ_W-1:0]   len2,
   input  logic [ND2_W-1:0]  nd2,
   output logic              known_out,
   output logic              known_val_out,
   output logic [WIDE_W-1:0] lhs,
   output logic [WIDE_W-1:0] rhs
);

   localparam int LO_W  = COORD_BITS + 1;
   localparam int HI_W  = SQ_W - LO_W;
   localparam int HH_W  = 2 * HI_W;
   localparam int HL_W  = HI_W + LO_W;
   localparam int LL_W  = 2 * LO_W;
   localparam int RQH_W = HI_W + ND2_W;
   localparam int RQL_W = LO_W + ND2_W;

   logic [HI_W-1:0]   mag_hi, len_hi;
   logic [LO_W-1:0]   mag_lo, len_lo;
   logic [HH_W-1:0]   pp_hh_in, pp_hh_ff;
   logic [HL_W-1:0]   pp_hl_in, pp_hl_ff;
   logic [LL_W-1:0]   pp_ll_in, pp_ll_ff;
   logic [RQH_W-1:0]  rq_h_in, rq_h_ff;
   logic [RQL_W-1:0]  rq_l_in, rq_l_ff;
   logic              known_s5_ff, val_s5_ff, known_ff, val_ff;
   logic [WIDE_W-1:0] lhs_in, rhs_in, lhs_ff, rhs_ff;

   // Split both wide operands and form the partial products
   always_comb begin
      mag_hi   = mag[SQ_W-1:LO_W];
      mag_lo   = mag[LO_W-1:0];
      len_hi   = len2[SQ_W-1:LO_W];
      len_lo   = len2[LO_W-1:0];
      pp_hh_in = HH_W'(mag_hi) * HH_W'(mag_hi);
      pp_hl_in = HL_W'(mag_hi) * HL_W'(mag_lo);
      pp_ll_in = LL_W'(mag_lo) * LL_W'(mag_lo);
      rq_h_in  = RQH_W'(len_hi) * RQH_W'(nd2);
      rq_l_in  = RQL_W'(len_lo) * RQL_W'(nd2);
   end

   // Weight and add the partial products; the middle term appears twice
   always_comb begin
      lhs_in = (WIDE_W'(pp_hh_ff) << (2 * LO_W)) + (WIDE_W'(pp_hl_ff) << (LO_W + 1))
             + WIDE_W'(pp_ll_ff);
      rhs_in = (WIDE_W'(rq_h_ff) << LO_W) + WIDE_W'(rq_l_ff);
   end

   // Advance the two stages
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         pp_hh_ff    <= pp_hh_in;
         pp_hl_ff    <= pp_hl_in;
         pp_ll_ff    <= pp_ll_in;
         rq_h_ff     <= rq_h_in;
         rq_l_ff     <= rq_l_in;
         known_s5_ff <= known;
         val_s5_ff   <= known_val;
      end
      if (stage_en[1]) begin
         lhs_ff   <= lhs_in;
         rhs_ff   <= rhs_in;
         known_ff <= known_s5_ff;
         val_ff   <= val_s5_ff;
      end
   end

   assign known_out     = known_ff;
   assign known_val_out = val_ff;
   assign lhs           = lhs_ff;
   assign rhs           = rhs_ff;

endmodule

// File: rtl/point_segment_proximity_test.sv
// Top level of the point-to-wall-segment proximity test pipeline.
//
//   Channel   Direction  Word contents
//   req_*     in         point, wall start and end coordinates, radius
//   rsp_*     out        within_res
//
// One word accepted per cycle while the output is not stalled; each result passes
// through six pipeline stages (differences, products, sums, selection,
// partial products of the wide compare, their sums) and the output register.
// The multipliers set the stage depth. Reset clears only the valid bits.
// A stage advances when the stage after it is empty or moving, so a stall on
// rsp_tready fills the bubbles first and then holds every word in place.
module point_segment_proximity_test import psp_pkg::*; #(
   parameter int  COORD_BITS = 18,
   localparam int REQ_BITS   = 6 * COORD_BITS + RADIUS_W,
   localparam int REQ_W      = ((REQ_BITS + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // point_x, point_y, start_x, start_y, end_x, end_y, radius, zero fill
   input  logic [REQ_W-1:0]  req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // within_res, zero fill
   output logic [RSP_W-1:0]  rsp_tdata
);

   localparam int SQ_W   = 2 * COORD_BITS + 1;
   localparam int SUM_W  = 2 * COORD_BITS + 2;
   localparam int LHS_W  = 2 * SQ_W;
   localparam int RHS_W  = SQ_W + ND2_W;
   localparam int WIDE_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;

   logic signed [COORD_BITS-1:0] point_x, point_y, start_x, start_y, end_x, end_y;
   logic [RADIUS_W-1:0]          radius;

   logic [NUM_STAGES-1:0] vld_in, vld_ff, stage_en;
   logic                  out_adv, out_vld_in, out_vld_ff, res_in, res_ff;

   sel_type                 sel;
   logic [SQ_W-1:0]         d1, d2, len2, mag, len2_s4;
   logic [ND2_W-1:0]        nd2, nd2_s4;
   logic signed [SUM_W-1:0] dot1, dot2, cross_prod;
   logic                    known_s4, val_s4, known_s6, val_s6;
   logic [WIDE_W-1:0]       lhs, rhs;

   // Unpack the request word
   always_comb begin
      point_x = req_tdata[0*COORD_BITS +: COORD_BITS];
      point_y = req_tdata[1*COORD_BITS +: COORD_BITS];
      start_x = req_tdata[2*COORD_BITS +: COORD_BITS];
      start_y = req_tdata[3*COORD_BITS +: COORD_BITS];
      end_x   = req_tdata[4*COORD_BITS +: COORD_BITS];
      end_y   = req_tdata[5*COORD_BITS +: COORD_BITS];
      radius  = req_tdata[6*COORD_BITS +: RADIUS_W];
   end

   // Let each stage load when its successor is empty or moving on
   always_comb begin
      out_adv                  = !out_vld_ff || rsp_tready;
      stage_en[NUM_STAGES-1]   = !vld_ff[NUM_STAGES-1] || out_adv;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !vld_ff[k] || stage_en[k+1];
      end
      vld_in[0] = stage_en[0] ? req_tvalid : vld_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         vld_in[k] = stage_en[k] ? vld_ff[k-1] : vld_ff[k];
      end
      out_vld_in = out_adv ? vld_ff[NUM_STAGES-1] : out_vld_ff;
      res_in     = known_s6 ? val_s6 : (lhs < rhs);
   end

   // Move the valid bits along and hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         vld_ff     <= vld_in;
         out_vld_ff <= out_vld_in;
      end
      if (out_adv) begin
         res_ff <= res_in;
      end
   end

   psp_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock      (clock),
      .stage_en   (stage_en[2:0]),
      .point_x    (point_x),
      .point_y    (point_y),
      .start_x    (start_x),
      .start_y    (start_y),
      .end_x      (end_x),
      .end_y      (end_y),
      .radius     (radius),
      .sel        (sel),
      .d1         (d1),
      .d2         (d2),
      .nd2        (nd2),
      .dot1       (dot1),
      .dot2       (dot2),
      .cross_prod (cross_prod),
      .len2       (len2)
   );

   psp_select #(.COORD_BITS(COORD_BITS)) u_select (
      .clock      (clock),
      .stage_en   (stage_en[3]),
      .sel        (sel),
      .d1         (d1),
      .d2         (d2),
      .nd2        (nd2),
      .dot1       (dot1),
      .dot2       (dot2),
      .cross_prod (cross_prod),
      .len2       (len2),
      .known      (known_s4),
      .known_val  (val_s4),
      .mag        (mag),
      .len2_out   (len2_s4),
      .nd2_out    (nd2_s4)
   );

   psp_wide_cmp #(.COORD_BITS(COORD_BITS)) u_wide_cmp (
      .clock         (clock),
      .stage_en      (stage_en[5:4]),
      .known         (known_s4),
      .known_val     (val_s4),
      .mag           (mag),
      .len2          (len2_s4),
      .nd2           (nd2_s4),
      .known_out     (known_s6),
      .known_val_out (val_s6),
      .lhs           (lhs),
      .rhs           (rhs)
   );

   assign req_tready = stage_en[0];
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(RSP_W - 1){1'b0}}, res_ff};

endmodule
